@@ rtl/core/scs_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Servo characterization sequencer package
// Shared widths, register indexes, sample kinds and payload types.
// ----------------------------------------------------------------------------
package scs_pkg;

  localparam int TIME_WIDTH     = 32;
  localparam int POSITION_WIDTH = 10;
  localparam int SPEED_WIDTH    = 9;
  localparam int MAG_WIDTH      = 8;
  localparam int SETTLE_WIDTH   = 24;
  localparam int INTERVAL_WIDTH = 20;
  localparam int COUNT_WIDTH    = 8;
  localparam int KIND_WIDTH     = 2;
  localparam int ADDR_WIDTH     = 3;
  localparam int WDATA_WIDTH    = 24;

  localparam logic [ADDR_WIDTH-1:0] REG_LOW_THRESHOLD  = 3'd0;
  localparam logic [ADDR_WIDTH-1:0] REG_HIGH_THRESHOLD = 3'd1;
  localparam logic [ADDR_WIDTH-1:0] REG_DRIVE_MAG      = 3'd2;
  localparam logic [ADDR_WIDTH-1:0] REG_SETTLE_TIME    = 3'd3;
  localparam logic [ADDR_WIDTH-1:0] REG_SAMPLE_IVL     = 3'd4;
  localparam logic [ADDR_WIDTH-1:0] REG_SAMPLE_TOTAL   = 3'd5;

  localparam logic [KIND_WIDTH-1:0] KIND_LOW_REACHED = 2'd0;
  localparam logic [KIND_WIDTH-1:0] KIND_TOP_REACHED = 2'd1;
  localparam logic [KIND_WIDTH-1:0] KIND_LINEARITY   = 2'd2;

  localparam logic [POSITION_WIDTH-1:0] RST_LOW_THRESHOLD  = 10'd100;
  localparam logic [POSITION_WIDTH-1:0] RST_HIGH_THRESHOLD = 10'd1000;
  localparam logic [MAG_WIDTH-1:0]      RST_DRIVE_MAG      = 8'd255;
  localparam logic [SETTLE_WIDTH-1:0]   RST_SETTLE_TIME    = 24'd500000;
  localparam logic [INTERVAL_WIDTH-1:0] RST_SAMPLE_IVL     = 20'd1000;
  localparam logic [COUNT_WIDTH-1:0]    RST_SAMPLE_TOTAL   = 8'd20;
  localparam logic signed [SPEED_WIDTH-1:0] RST_SPEED      = -9'sd255;

  typedef struct packed {
    logic [TIME_WIDTH-1:0]     time_us;
    logic [POSITION_WIDTH-1:0] position;
  } poll_t;

  typedef struct packed {
    logic signed [SPEED_WIDTH-1:0] motor_speed;
    logic                          motor_enabled;
    logic                          sample_valid;
    logic [KIND_WIDTH-1:0]         sample_kind;
    logic [TIME_WIDTH-1:0]         sample_time;
    logic [POSITION_WIDTH-1:0]     sample_position;
    logic [COUNT_WIDTH-1:0]        sample_number;
    logic                          done_res;
  } result_t;

  typedef struct packed {
    logic [ADDR_WIDTH-1:0]  addr;
    logic [WDATA_WIDTH-1:0] wdata;
  } cfg_wr_t;

  typedef struct packed {
    logic [POSITION_WIDTH-1:0] low_threshold;
    logic [POSITION_WIDTH-1:0] high_threshold;
    logic [MAG_WIDTH-1:0]      drive_magnitude;
    logic [SETTLE_WIDTH-1:0]   settle_time_us;
    logic [INTERVAL_WIDTH-1:0] sample_interval_us;
    logic [COUNT_WIDTH-1:0]    sample_total;
  } cfg_regs_t;

endpackage

@@ rtl/core/scs_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Servo characterization sequencer channels
// Valid/ready interfaces for polls, results and configuration writes.
// ----------------------------------------------------------------------------
interface scs_poll_if import scs_pkg::*;;
  logic  valid;
  logic  ready;
  poll_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface scs_result_if import scs_pkg::*;;
  logic    valid;
  logic    ready;
  result_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface scs_cfg_if import scs_pkg::*;;
  logic    valid;
  logic    ready;
  cfg_wr_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ rtl/core/scs_seq.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Servo characterization sequencer step
// Holds the test sequence state and computes the result of one poll.
// ----------------------------------------------------------------------------
module scs_seq import scs_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      advance,
  input  poll_t     item,
  input  cfg_regs_t regs,
  output result_t   res
);

  typedef enum logic [2:0] {
    SWING_LOW,
    SWING_TOP,
    RETURN_LOW,
    SAMPLING,
    DONE
  } phase_t;

  phase_t                        phase, phase_next;
  logic signed [SPEED_WIDTH-1:0] speed_command, speed_command_next;
  logic                          motor_on, motor_on_next;
  logic [COUNT_WIDTH-1:0]        sample_counter, sample_counter_next;
  logic [TIME_WIDTH-1:0]         next_sample_due, next_sample_due_next;

  logic                          rec;
  logic [KIND_WIDTH-1:0]         kind;
  logic [COUNT_WIDTH-1:0]        number;
  logic signed [SPEED_WIDTH-1:0] drive_fwd;
  logic [COUNT_WIDTH-1:0]        count_inc;

  assign drive_fwd = $signed({1'b0, regs.drive_magnitude});

  always_comb begin
    phase_next           = phase;
    speed_command_next   = speed_command;
    motor_on_next        = motor_on;
    sample_counter_next  = sample_counter;
    next_sample_due_next = next_sample_due;
    rec                  = 1'b0;
    kind                 = KIND_LOW_REACHED;
    number               = '0;
    count_inc            = '0;

    unique case (phase)
      SWING_LOW: begin
        if (item.position < regs.low_threshold) begin
          rec                 = 1'b1;
          kind                = KIND_LOW_REACHED;
          number              = sample_counter;
          sample_counter_next = sample_counter + 1'b1;
          speed_command_next  = drive_fwd;
          phase_next          = SWING_TOP;
        end
      end
      SWING_TOP: begin
        if (item.position >= regs.high_threshold) begin
          rec                 = 1'b1;
          kind                = KIND_TOP_REACHED;
          number              = sample_counter;
          sample_counter_next = '0;
          speed_command_next  = -drive_fwd;
          phase_next          = RETURN_LOW;
        end
      end
      default: ;
    endcase

    if (!rec && phase_next == RETURN_LOW && item.position <= regs.low_threshold) begin
      speed_command_next   = '0;
      next_sample_due_next = item.time_us + TIME_WIDTH'(regs.settle_time_us);
      phase_next           = SAMPLING;
    end

    if (!rec && phase_next == SAMPLING && item.time_us >= next_sample_due_next) begin
      rec                  = 1'b1;
      kind                 = KIND_LINEARITY;
      number               = sample_counter_next;
      count_inc            = sample_counter_next + 1'b1;
      sample_counter_next  = count_inc;
      next_sample_due_next = next_sample_due_next + TIME_WIDTH'(regs.sample_interval_us);
      if (count_inc >= regs.sample_total) begin
        motor_on_next = 1'b0;
        phase_next    = DONE;
      end
    end
  end

  always_comb begin
    res.motor_speed     = speed_command_next;
    res.motor_enabled   = motor_on_next;
    res.sample_valid    = rec;
    res.sample_kind     = rec ? kind : '0;
    res.sample_time     = rec ? item.time_us : '0;
    res.sample_position = rec ? item.position : '0;
    res.sample_number   = rec ? number : '0;
    res.done_res        = (phase_next == DONE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= SWING_LOW;
      speed_command   <= RST_SPEED;
      motor_on        <= 1'b1;
      sample_counter  <= '0;
      next_sample_due <= '0;
    end else if (advance) begin
      phase           <= phase_next;
      speed_command   <= speed_command_next;
      motor_on        <= motor_on_next;
      sample_counter  <= sample_counter_next;
      next_sample_due <= next_sample_due_next;
    end
  end

endmodule

@@ rtl/core/servo_characterization_sequencer_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Servo characterization sequencer
// Runs the swing, return and linearity sampling test, one result per poll.
// ----------------------------------------------------------------------------
//  Channel  Role    Payload
//  poll     sink    time_us, position
//  result   source  motor command, status and at most one sample
//  cfg      sink    register index and write data, always ready
//
// A poll is registered on transfer, evaluated against the sequence state and
// written to the result register. One poll per cycle is sustained while
// results are taken. A stalled result keeps the registered poll waiting,
// and the poll input stalls once both registers are full.
// Reset restores the register defaults and starts the sequence at the swing
// toward the low end. A stalled result holds the pipeline until it is taken.
// ----------------------------------------------------------------------------
module servo_characterization_sequencer_core import scs_pkg::*; (
  input  logic clk,
  input  logic rst,
  scs_poll_if.sink     poll,
  scs_result_if.source result,
  scs_cfg_if.sink      cfg
);

  cfg_regs_t regs;
  logic      in_full;
  poll_t     in_data;
  logic      res_full;
  result_t   res_data;
  result_t   res_next;
  logic      advance;

  assign advance      = in_full && (!res_full || result.ready);
  assign poll.ready   = !in_full || advance;
  assign result.valid = res_full;
  assign result.data  = res_data;
  assign cfg.ready    = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.low_threshold      <= RST_LOW_THRESHOLD;
      regs.high_threshold     <= RST_HIGH_THRESHOLD;
      regs.drive_magnitude    <= RST_DRIVE_MAG;
      regs.settle_time_us     <= RST_SETTLE_TIME;
      regs.sample_interval_us <= RST_SAMPLE_IVL;
      regs.sample_total       <= RST_SAMPLE_TOTAL;
    end else if (cfg.valid) begin
      unique case (cfg.data.addr)
        REG_LOW_THRESHOLD:  regs.low_threshold      <= cfg.data.wdata[POSITION_WIDTH-1:0];
        REG_HIGH_THRESHOLD: regs.high_threshold     <= cfg.data.wdata[POSITION_WIDTH-1:0];
        REG_DRIVE_MAG:      regs.drive_magnitude    <= cfg.data.wdata[MAG_WIDTH-1:0];
        REG_SETTLE_TIME:    regs.settle_time_us     <= cfg.data.wdata[SETTLE_WIDTH-1:0];
        REG_SAMPLE_IVL:     regs.sample_interval_us <= cfg.data.wdata[INTERVAL_WIDTH-1:0];
        REG_SAMPLE_TOTAL:   regs.sample_total       <= cfg.data.wdata[COUNT_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (poll.valid && poll.ready) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (poll.valid && poll.ready) begin
      in_data <= poll.data;
    end
  end

  scs_seq u_seq (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .item    (in_data),
    .regs    (regs),
    .res     (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_full <= 1'b0;
    end else if (advance) begin
      res_full <= 1'b1;
    end else if (result.ready) begin
      res_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_data <= res_next;
    end
  end

  a_advance_fills_result : assert property (
    @(posedge clk) disable iff (rst) advance |=> res_full
  ) else $error("evaluated poll did not reach the result register");

  a_held_poll_kept : assert property (
    @(posedge clk) disable iff (rst) (in_full && !advance) |=> in_full
  ) else $error("registered poll dropped without evaluation");

  a_done_motor_off : assert property (
    @(posedge clk) disable iff (rst)
      (res_full && res_data.done_res) |-> (!res_data.motor_enabled && res_data.motor_speed == '0)
  ) else $error("sequence done with motor still driven");

  a_no_sample_zero : assert property (
    @(posedge clk) disable iff (rst)
      (res_full && !res_data.sample_valid) |->
        (res_data.sample_time == '0 && res_data.sample_position == '0 &&
         res_data.sample_number == '0 && res_data.sample_kind == '0)
  ) else $error("sample fields set without a recorded sample");

endmodule

@@ tb/sv/tb_servo_characterization_sequencer_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Servo characterization sequencer testbench
// Walks one full test sequence through the swing, return, sampling and done
// phases. A clocked driver sends polls from a queue and a clocked monitor
// checks every result against a sequence predictor kept in the testbench.
// Registers are rewritten between phases while the block is idle, and the
// sender and receiver idle at random in several patterns.
// ----------------------------------------------------------------------------
module tb_servo_characterization_sequencer_core import scs_pkg::*;;

  typedef enum logic [2:0] {
    SEQ_SWING_LOW,
    SEQ_SWING_TOP,
    SEQ_RETURN_LOW,
    SEQ_SAMPLING,
    SEQ_DONE
  } seq_phase_t;

  localparam int STALL_LIMIT = 2000;
  localparam int HOLD_CYCLES = 300;

  logic clk = 1'b0;
  logic rst;

  scs_poll_if   poll_ch ();
  scs_result_if result_ch ();
  scs_cfg_if    cfg_ch ();

  servo_characterization_sequencer_core uut (
    .clk    (clk),
    .rst    (rst),
    .poll   (poll_ch),
    .result (result_ch),
    .cfg    (cfg_ch)
  );

  always #5 clk = ~clk;

  cfg_regs_t  shadow_cfg;
  seq_phase_t seq_phase;
  logic signed [SPEED_WIDTH-1:0] seq_speed;
  logic                          seq_motor_on;
  logic [COUNT_WIDTH-1:0]        seq_count;
  logic [TIME_WIDTH-1:0]         seq_due;

  poll_t   polls_to_send[$];
  result_t predicted_reports[$];
  cfg_wr_t cfg_todo[$];

  int send_idle_pct;
  int recv_stall_pct;
  logic pressure_armed;
  logic pressure_done;
  int hold_left;
  int quiet_cycles;

  int polls_added;
  int polls_sent;
  int results_seen;
  int mismatches;
  int reg_writes;
  int swing_samples;
  int linearity_samples;

  function automatic result_t sequence_step(poll_t p);
    result_t r;
    logic rec;
    logic [KIND_WIDTH-1:0] kind;
    logic [COUNT_WIDTH-1:0] num;
    rec = 1'b0;
    kind = KIND_LOW_REACHED;
    num = '0;
    if (seq_phase == SEQ_SWING_LOW) begin
      if (p.position < shadow_cfg.low_threshold) begin
        rec = 1'b1;
        kind = KIND_LOW_REACHED;
        num = seq_count;
        seq_count = seq_count + 1'b1;
        seq_speed = $signed({1'b0, shadow_cfg.drive_magnitude});
        seq_phase = SEQ_SWING_TOP;
      end
    end else if (seq_phase == SEQ_SWING_TOP) begin
      if (p.position >= shadow_cfg.high_threshold) begin
        rec = 1'b1;
        kind = KIND_TOP_REACHED;
        num = seq_count;
        seq_count = '0;
        seq_speed = -$signed({1'b0, shadow_cfg.drive_magnitude});
        seq_phase = SEQ_RETURN_LOW;
      end
    end
    if (!rec && seq_phase == SEQ_RETURN_LOW) begin
      if (p.position <= shadow_cfg.low_threshold) begin
        seq_speed = '0;
        seq_due = p.time_us + TIME_WIDTH'(shadow_cfg.settle_time_us);
        seq_phase = SEQ_SAMPLING;
      end
    end
    if (!rec && seq_phase == SEQ_SAMPLING) begin
      if (p.time_us >= seq_due) begin
        rec = 1'b1;
        kind = KIND_LINEARITY;
        num = seq_count;
        seq_count = seq_count + 1'b1;
        seq_due = seq_due + TIME_WIDTH'(shadow_cfg.sample_interval_us);
        if (seq_count >= shadow_cfg.sample_total) begin
          seq_motor_on = 1'b0;
          seq_phase = SEQ_DONE;
        end
      end
    end
    r = '0;
    r.motor_speed = seq_speed;
    r.motor_enabled = seq_motor_on;
    r.sample_valid = rec;
    if (rec) begin
      r.sample_kind = kind;
      r.sample_time = p.time_us;
      r.sample_position = p.position;
      r.sample_number = num;
    end
    r.done_res = (seq_phase == SEQ_DONE);
    return r;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("result %0d %s: expected %0h, got %0h", results_seen, name, want, got);
      end
    end
  endfunction

  // Driver: a poll stays offered until its transfer, then the next one follows.
  always @(posedge clk) begin
    result_t pred;
    if (rst) begin
      poll_ch.valid <= 1'b0;
    end else begin
      if (poll_ch.valid && poll_ch.ready) begin
        pred = sequence_step(poll_ch.data);
        predicted_reports.push_back(pred);
        polls_sent++;
        if (pred.sample_valid) begin
          if (pred.sample_kind == KIND_LINEARITY) begin
            linearity_samples++;
          end else begin
            swing_samples++;
          end
        end
      end
      if (!poll_ch.valid || poll_ch.ready) begin
        if (polls_to_send.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          poll_ch.valid <= 1'b1;
          poll_ch.data <= polls_to_send.pop_front();
        end else begin
          poll_ch.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      result_ch.ready <= 1'b0;
    end else begin
      if (result_ch.valid && result_ch.ready) begin
        results_seen++;
        if (predicted_reports.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("result %0d arrived with nothing predicted", results_seen);
          end
        end else begin
          want = predicted_reports.pop_front();
          check_field("motor_speed", 32'($unsigned(want.motor_speed)),
                      32'($unsigned(result_ch.data.motor_speed)));
          check_field("motor_enabled", 32'(want.motor_enabled),
                      32'(result_ch.data.motor_enabled));
          check_field("sample_valid", 32'(want.sample_valid),
                      32'(result_ch.data.sample_valid));
          check_field("sample_kind", 32'(want.sample_kind),
                      32'(result_ch.data.sample_kind));
          check_field("sample_time", want.sample_time, result_ch.data.sample_time);
          check_field("sample_position", 32'(want.sample_position),
                      32'(result_ch.data.sample_position));
          check_field("sample_number", 32'(want.sample_number),
                      32'(result_ch.data.sample_number));
          check_field("done_res", 32'(want.done_res), 32'(result_ch.data.done_res));
        end
      end
      result_ch.ready <= (hold_left == 0) && ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
      pressure_done <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (pressure_armed && !pressure_done) begin
      hold_left <= HOLD_CYCLES;
      pressure_done <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles <= 0;
    end else if ((poll_ch.valid && poll_ch.ready) || (result_ch.valid && result_ch.ready)
                 || (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("no transfer for %0d cycles", quiet_cycles);
      $display("tb_servo_characterization_sequencer_core NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic void add_poll(logic [TIME_WIDTH-1:0] t, logic [POSITION_WIDTH-1:0] p);
    poll_t item;
    item.time_us = t;
    item.position = p;
    polls_to_send.push_back(item);
    polls_added++;
  endfunction

  function automatic void stage_cfg(logic [ADDR_WIDTH-1:0] idx, logic [WDATA_WIDTH-1:0] val);
    cfg_wr_t w;
    w.addr = idx;
    w.wdata = val;
    cfg_todo.push_back(w);
  endfunction

  task automatic set_idle(int m);
    case (m % 4)
      0: begin
        send_idle_pct <= 0;
        recv_stall_pct <= 0;
      end
      1: begin
        send_idle_pct <= 48;
        recv_stall_pct <= 0;
      end
      2: begin
        send_idle_pct <= 0;
        recv_stall_pct <= 48;
      end
      default: begin
        send_idle_pct <= 34;
        recv_stall_pct <= 34;
      end
    endcase
  endtask

  task automatic apply_cfg();
    cfg_wr_t w;
    while (cfg_todo.size() != 0) begin
      w = cfg_todo.pop_front();
      cfg_ch.data <= w;
      cfg_ch.valid <= 1'b1;
      @(posedge clk);
      while (!cfg_ch.ready) @(posedge clk);
      reg_writes++;
      case (w.addr)
        REG_LOW_THRESHOLD: shadow_cfg.low_threshold = w.wdata[POSITION_WIDTH-1:0];
        REG_HIGH_THRESHOLD: shadow_cfg.high_threshold = w.wdata[POSITION_WIDTH-1:0];
        REG_DRIVE_MAG: shadow_cfg.drive_magnitude = w.wdata[MAG_WIDTH-1:0];
        REG_SETTLE_TIME: shadow_cfg.settle_time_us = w.wdata[SETTLE_WIDTH-1:0];
        REG_SAMPLE_IVL: shadow_cfg.sample_interval_us = w.wdata[INTERVAL_WIDTH-1:0];
        REG_SAMPLE_TOTAL: shadow_cfg.sample_total = w.wdata[COUNT_WIDTH-1:0];
        default: ;
      endcase
    end
    cfg_ch.valid <= 1'b0;
  endtask

  // A phase is over once every queued poll has come back as a checked result.
  task automatic finish_phase();
    @(posedge clk);
    while (results_seen != polls_added) begin
      @(posedge clk);
    end
  endtask

  initial begin
    int m;
    int n;
    logic [TIME_WIDTH-1:0] clock_us;
    rst = 1'b1;
    poll_ch.valid = 1'b0;
    poll_ch.data = '0;
    result_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    pressure_armed = 1'b0;
    polls_added = 0;
    polls_sent = 0;
    results_seen = 0;
    mismatches = 0;
    reg_writes = 0;
    swing_samples = 0;
    linearity_samples = 0;
    shadow_cfg.low_threshold = RST_LOW_THRESHOLD;
    shadow_cfg.high_threshold = RST_HIGH_THRESHOLD;
    shadow_cfg.drive_magnitude = RST_DRIVE_MAG;
    shadow_cfg.settle_time_us = RST_SETTLE_TIME;
    shadow_cfg.sample_interval_us = RST_SAMPLE_IVL;
    shadow_cfg.sample_total = RST_SAMPLE_TOTAL;
    seq_phase = SEQ_SWING_LOW;
    seq_speed = RST_SPEED;
    seq_motor_on = 1'b1;
    seq_count = '0;
    seq_due = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Reset register values; a position equal to the low threshold is not below it.
    add_poll(32'h0000_0000, 10'h3FF);
    add_poll(32'hFFFF_FFFF, 10'd100);
    add_poll(32'h5555_5555, 10'h155);
    add_poll(32'hAAAA_AAAA, 10'h2AA);
    add_poll(32'h8000_0000, 10'd101);
    add_poll(32'h0000_0001, 10'd512);
    finish_phase();

    // A zero low threshold keeps the swing toward the low end open for any position.
    stage_cfg(REG_LOW_THRESHOLD, 24'd0);
    stage_cfg(REG_HIGH_THRESHOLD, 24'd1023);
    stage_cfg(REG_DRIVE_MAG, 24'd0);
    stage_cfg(REG_SETTLE_TIME, 24'hFF_FFFF);
    stage_cfg(REG_SAMPLE_IVL, 24'd1);
    stage_cfg(REG_SAMPLE_TOTAL, 24'd255);
    apply_cfg();
    for (m = 0; m < 4; m++) begin
      set_idle(m);
      if (m == 0) begin
        pressure_armed <= 1'b1;
      end
      for (n = 0; n < 45; n++) add_poll($urandom, 10'($urandom_range(0, 1023)));
      finish_phase();
    end

    // High threshold below the low one: the top is not checked in the poll that
    // records the low end.
    set_idle(0);
    stage_cfg(REG_LOW_THRESHOLD, 24'd500);
    stage_cfg(REG_HIGH_THRESHOLD, 24'd200);
    stage_cfg(REG_DRIVE_MAG, 24'd37);
    apply_cfg();
    add_poll($urandom, 10'd250);
    finish_phase();

    stage_cfg(REG_HIGH_THRESHOLD, 24'd1023);
    stage_cfg(REG_DRIVE_MAG, 24'd1);
    apply_cfg();
    for (m = 0; m < 4; m++) begin
      set_idle(m + 1);
      for (n = 0; n < 30; n++) add_poll($urandom, 10'($urandom_range(0, 1022)));
      finish_phase();
    end

    // The top is recorded and the return is first checked on the next poll.
    stage_cfg(REG_HIGH_THRESHOLD, 24'd200);
    stage_cfg(REG_DRIVE_MAG, 24'd255);
    apply_cfg();
    add_poll($urandom, 10'd300);
    finish_phase();

    stage_cfg(REG_LOW_THRESHOLD, 24'd0);
    apply_cfg();
    for (m = 0; m < 4; m++) begin
      set_idle(m + 2);
      for (n = 0; n < 20; n++) add_poll($urandom, 10'($urandom_range(1, 1023)));
      finish_phase();
    end

    // Zero settle time samples in the stopping poll, and the due time wraps.
    stage_cfg(REG_LOW_THRESHOLD, 24'd1023);
    stage_cfg(REG_SETTLE_TIME, 24'd0);
    stage_cfg(REG_SAMPLE_IVL, 24'd1048575);
    apply_cfg();
    add_poll(32'hFFFF_F000, 10'($urandom_range(0, 1023)));
    finish_phase();

    for (m = 0; m < 4; m++) begin
      set_idle(m + 3);
      if (m == 1) stage_cfg(REG_SAMPLE_IVL, 24'd5000);
      if (m == 2) stage_cfg(REG_SAMPLE_IVL, 24'd1);
      if (m == 3) stage_cfg(REG_SAMPLE_IVL, 24'($urandom_range(1, 1048575)));
      apply_cfg();
      clock_us = seq_due - $urandom_range(0, shadow_cfg.sample_interval_us);
      for (n = 0; n < 50; n++) begin
        if ($urandom_range(0, 9) == 0) begin
          add_poll($urandom, 10'($urandom_range(0, 1023)));
        end else begin
          clock_us = clock_us
                     + $urandom_range(0, 2 * int'(shadow_cfg.sample_interval_us));
          add_poll(clock_us, 10'($urandom_range(0, 1023)));
        end
      end
      finish_phase();
    end

    // A sample total of zero ends the sequence at the next sample.
    set_idle(0);
    stage_cfg(REG_SAMPLE_TOTAL, 24'd0);
    apply_cfg();
    for (n = 0; n < 8; n++) begin
      clock_us = clock_us + $urandom_range(0, 2 * int'(shadow_cfg.sample_interval_us));
      add_poll(clock_us, 10'($urandom_range(0, 1023)));
    end
    add_poll(32'hFFFF_FFFF, 10'h3FF);
    add_poll(32'hFFFF_FFFF, 10'h000);
    finish_phase();

    // After the end nothing moves, whatever the registers hold.
    stage_cfg(REG_LOW_THRESHOLD, 24'($urandom_range(0, 1023)));
    stage_cfg(REG_HIGH_THRESHOLD, 24'd0);
    stage_cfg(REG_DRIVE_MAG, 24'd128);
    stage_cfg(REG_SETTLE_TIME, 24'($urandom));
    stage_cfg(REG_SAMPLE_IVL, 24'($urandom_range(1, 1048575)));
    stage_cfg(REG_SAMPLE_TOTAL, 24'($urandom_range(1, 255)));
    apply_cfg();
    add_poll(32'h0000_0000, 10'h000);
    add_poll(32'hFFFF_FFFF, 10'h3FF);
    for (m = 0; m < 4; m++) begin
      set_idle(m);
      for (n = 0; n < 20; n++) add_poll($urandom, 10'($urandom_range(0, 1023)));
      finish_phase();
    end

    repeat (8) @(posedge clk);
    $display("Sequence run: %0d polls and %0d results checked, %0d register writes.",
             polls_sent, results_seen, reg_writes);
    $display("Samples recorded: %0d swing, %0d linearity; final phase %s.",
             swing_samples, linearity_samples, seq_phase.name());
    if (mismatches == 0 && predicted_reports.size() == 0) begin
      $display("tb_servo_characterization_sequencer_core OK");
    end else begin
      $display("tb_servo_characterization_sequencer_core NOT OK");
    end
    $finish;
  end

endmodule

@@ servo_characterization_sequencer_core.f @@
rtl/core/scs_pkg.sv
rtl/core/scs_if.sv
rtl/core/scs_seq.sv
rtl/core/servo_characterization_sequencer_core.sv
tb/sv/tb_servo_characterization_sequencer_core.sv
